### rtl/plfx_pkg.sv
// Package for the periodic limited face flux block.
// Widths, limits, state codes and the flux helper; no dependencies.
package plfx_pkg;

  localparam int DATA_W    = 32;
  localparam int IDX_W     = 17;
  localparam int FACE_W    = 34;  // face value, signed, exact
  localparam int MAG_W     = 33;  // magnitude of a cell difference
  localparam int SQ_W      = 66;
  localparam int NUM_W     = 98;
  localparam int QUO_W     = 33;
  localparam int MAX_CELLS = 65536;
  localparam int STEP_W    = 3;

  localparam logic [IDX_W-1:0] LAST_K = IDX_W'(MAX_CELLS - 1);

  localparam logic [STEP_W-1:0] STEP_PREV  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_WRAP  = 3'd1;
  localparam logic [STEP_W-1:0] STEP_ZERO  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_ONE   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_DUP   = 3'd4;

  localparam logic [1:0] JOB_LAST = 2'd0;
  localparam logic [1:0] JOB_U0   = 2'd1;
  localparam logic [1:0] JOB_U1   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISPATCH, ST_START, ST_WAIT, ST_EMIT, ST_ERR
  } ctl_state_t;

  typedef enum logic [2:0] {
    FU_IDLE, FU_SQ1, FU_SQ2, FU_NLO, FU_NHI, FU_DIV, FU_DONE
  } fu_state_t;

  // floor(-(ua+ub)/2), saturated to 32 bits
  function automatic logic signed [DATA_W-1:0] flux_of(
    input logic signed [FACE_W-1:0] ua,
    input logic signed [FACE_W-1:0] ub
  );
    logic signed [FACE_W+1:0] s;
    logic signed [FACE_W+1:0] h;
    s = -((FACE_W+2)'(ua) + (FACE_W+2)'(ub));
    h = s >>> 1;
    if (h > (FACE_W+2)'(64'sd2147483647))
      flux_of = 32'sh7FFFFFFF;
    else if (h < -(FACE_W+2)'(64'sd2147483648))
      flux_of = 32'sh80000000;
    else
      flux_of = h[DATA_W-1:0];
  endfunction

endpackage

### rtl/plfx_if.sv
// Channel interfaces for cell words in and flux words out.
// Depends on plfx_pkg.
interface plfx_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [plfx_pkg::DATA_W-1:0] cell_value;
  logic                               final_cell;
  modport source(output valid, cell_value, final_cell, input ready);
  modport sink(input valid, cell_value, final_cell, output ready);
endinterface

interface plfx_out_if;
  logic                               valid;
  logic                               ready;
  logic        [plfx_pkg::IDX_W-1:0]  face_index;
  logic signed [plfx_pkg::DATA_W-1:0] face_flux;
  logic                               grid_done;
  logic                               grid_too_short;
  modport source(output valid, face_index, face_flux, grid_done, grid_too_short,
                 input ready);
  modport sink(input valid, face_index, face_flux, grid_done, grid_too_short,
               output ready);
endinterface

### rtl/plfx_face_unit.sv
// Limited face value u = prev + trunc(d1*d2^2/(d1^2+d2^2)).
// Shared 33x33 multiplier, then restoring divider one bit a cycle. Uses plfx_pkg.
module plfx_face_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [plfx_pkg::DATA_W-1:0]  older,
  input  logic signed [plfx_pkg::DATA_W-1:0]  prev,
  input  logic signed [plfx_pkg::DATA_W-1:0]  cur,
  output logic                                done,
  output logic signed [plfx_pkg::FACE_W-1:0]  face
);

  plfx_pkg::fu_state_t state, state_next;

  logic signed [plfx_pkg::DATA_W:0]   d1, d2;
  logic        [plfx_pkg::MAG_W-1:0]  m1, m2;
  logic                               neg;
  logic signed [plfx_pkg::DATA_W-1:0] base;
  logic        [plfx_pkg::SQ_W-1:0]   sq1, sq2, den;
  logic        [plfx_pkg::NUM_W-1:0]  num, den_sh;
  logic        [plfx_pkg::QUO_W-1:0]  quo;
  logic        [5:0]                  cnt;
  logic        [plfx_pkg::MAG_W-1:0]  mul_a, mul_b;
  logic        [plfx_pkg::SQ_W-1:0]   prod;
  logic                               fits;
  logic signed [plfx_pkg::FACE_W-1:0] term;

  assign d1 = (plfx_pkg::DATA_W+1)'(prev) - (plfx_pkg::DATA_W+1)'(older);
  assign d2 = (plfx_pkg::DATA_W+1)'(cur) - (plfx_pkg::DATA_W+1)'(prev);

  always_comb begin
    case (state)
      plfx_pkg::FU_SQ1: mul_a = m1;
      plfx_pkg::FU_SQ2: mul_a = m2;
      plfx_pkg::FU_NLO: mul_a = sq2[plfx_pkg::MAG_W-1:0];
      default:          mul_a = sq2[2*plfx_pkg::MAG_W-1:plfx_pkg::MAG_W];
    endcase
  end

  // second operand is m1 except while squaring d2
  assign mul_b = (state == plfx_pkg::FU_SQ2) ? m2 : m1;
  assign prod  = plfx_pkg::SQ_W'(mul_a) * plfx_pkg::SQ_W'(mul_b);
  assign fits = num >= den_sh;
  assign term = neg ? -plfx_pkg::FACE_W'(quo) : plfx_pkg::FACE_W'(quo);
  assign face = plfx_pkg::FACE_W'(base) + term;
  assign done = (state == plfx_pkg::FU_DONE);

  always_ff @(posedge clk) begin
    if (rst) state <= plfx_pkg::FU_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      plfx_pkg::FU_IDLE: if (start) begin
        state_next = (d1 == '0 || d2 == '0) ? plfx_pkg::FU_DONE : plfx_pkg::FU_SQ1;
      end
      plfx_pkg::FU_SQ1: state_next = plfx_pkg::FU_SQ2;
      plfx_pkg::FU_SQ2: state_next = plfx_pkg::FU_NLO;
      plfx_pkg::FU_NLO: state_next = plfx_pkg::FU_NHI;
      plfx_pkg::FU_NHI: state_next = plfx_pkg::FU_DIV;
      plfx_pkg::FU_DIV: if (cnt == '0) begin
        state_next = plfx_pkg::FU_DONE;
      end
      plfx_pkg::FU_DONE: state_next = plfx_pkg::FU_IDLE;
      default: state_next = plfx_pkg::FU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      plfx_pkg::FU_IDLE: if (start) begin
        m1   <= d1[plfx_pkg::DATA_W] ? plfx_pkg::MAG_W'(-d1) : plfx_pkg::MAG_W'(d1);
        m2   <= d2[plfx_pkg::DATA_W] ? plfx_pkg::MAG_W'(-d2) : plfx_pkg::MAG_W'(d2);
        neg  <= d1[plfx_pkg::DATA_W];
        base <= prev;
        quo  <= '0;
      end
      plfx_pkg::FU_SQ1: sq1 <= prod;
      plfx_pkg::FU_SQ2: sq2 <= prod;
      plfx_pkg::FU_NLO: begin
        num <= plfx_pkg::NUM_W'(prod);
        den <= sq1 + sq2;
      end
      plfx_pkg::FU_NHI: begin
        num    <= num + (plfx_pkg::NUM_W'(prod) << plfx_pkg::MAG_W);
        den_sh <= plfx_pkg::NUM_W'(den) << (plfx_pkg::QUO_W - 1);
        cnt    <= 6'(plfx_pkg::QUO_W - 1);
      end
      plfx_pkg::FU_DIV: begin
        if (fits) num <= num - den_sh;
        quo    <= {quo[plfx_pkg::QUO_W-2:0], fits};
        den_sh <= den_sh >> 1;
        cnt    <= cnt - 6'd1;
      end
      default: ;
    endcase
  end

endmodule

### rtl/periodic_limited_face_flux_top.sv
// Periodic MUSCL face flux with van Albada limiter, streamed cell by cell.
// Each face value: start, 4 multiply steps, 33 divide steps, done; straight from start
// to done when a cell difference is zero. A plain cell from the third on needs one face
// value, the last cell three face values and five flux words (four on a three-cell grid).
// Throughput: one cell at a time; the shared face unit and output stalls set the pace.
// Reset (rst, synchronous): grid state cleared, no output word pending.
module periodic_limited_face_flux_top (
  input logic       clk,
  input logic       rst,
  plfx_in_if.sink   cells,
  plfx_out_if.source fluxes
);

  plfx_pkg::ctl_state_t state, state_next;

  logic signed [plfx_pkg::DATA_W-1:0] r0, r1, r2, fc0, fc1;
  logic signed [plfx_pkg::FACE_W-1:0] prev_u, face_two, u_last, u0, u1;
  logic        [plfx_pkg::IDX_W-1:0]  cell_count, k;
  logic                               fin;
  logic        [1:0]                  job;
  logic        [plfx_pkg::STEP_W-1:0] step;

  logic                               fu_start, fu_done;
  logic signed [plfx_pkg::DATA_W-1:0] op_a, op_b, op_c;
  logic signed [plfx_pkg::FACE_W-1:0] fu_face;

  logic                               accept, slot_free;
  logic signed [plfx_pkg::FACE_W-1:0] ua, ub;
  logic        [plfx_pkg::IDX_W-1:0]  idx_sel;

  assign accept    = cells.valid && cells.ready;
  assign slot_free = !fluxes.valid || fluxes.ready;
  assign cells.ready = (state == plfx_pkg::ST_IDLE);
  assign fu_start  = (state == plfx_pkg::ST_START);

  always_comb begin
    case (job)
      plfx_pkg::JOB_U0: begin op_a = r1; op_b = r2;  op_c = fc0; end
      plfx_pkg::JOB_U1: begin op_a = r2; op_b = fc0; op_c = fc1; end
      default:          begin op_a = r0; op_b = r1;  op_c = r2;  end
    endcase
  end

  plfx_face_unit u_face (
    .clk(clk), .rst(rst), .start(fu_start),
    .older(op_a), .prev(op_b), .cur(op_c),
    .done(fu_done), .face(fu_face)
  );

  always_comb begin
    case (step)
      plfx_pkg::STEP_PREV: begin ua = prev_u; ub = u_last;   idx_sel = k - 1'b1; end
      plfx_pkg::STEP_WRAP: begin ua = u_last; ub = u0;       idx_sel = k;        end
      plfx_pkg::STEP_ZERO: begin ua = u0;     ub = u1;       idx_sel = '0;       end
      plfx_pkg::STEP_ONE:  begin ua = u1;     ub = face_two; idx_sel = 17'd1;    end
      default:             begin ua = u0;     ub = u1;       idx_sel = k + 1'b1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= plfx_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      plfx_pkg::ST_IDLE: if (accept) state_next = plfx_pkg::ST_DISPATCH;
      plfx_pkg::ST_DISPATCH: begin
        if (k < 17'd2) state_next = fin ? plfx_pkg::ST_ERR : plfx_pkg::ST_IDLE;
        else           state_next = plfx_pkg::ST_START;
      end
      plfx_pkg::ST_START: state_next = plfx_pkg::ST_WAIT;
      plfx_pkg::ST_WAIT: if (fu_done) begin
        if (fin && job != plfx_pkg::JOB_U1) state_next = plfx_pkg::ST_START;
        else if (fin || k > 17'd2)          state_next = plfx_pkg::ST_EMIT;
        else                                state_next = plfx_pkg::ST_IDLE;
      end
      plfx_pkg::ST_EMIT: begin
        if (slot_free && (!fin || step == plfx_pkg::STEP_DUP))
          state_next = plfx_pkg::ST_IDLE;
      end
      plfx_pkg::ST_ERR: if (slot_free) state_next = plfx_pkg::ST_IDLE;
      default: state_next = plfx_pkg::ST_IDLE;
    endcase
  end

  // grid state
  always_ff @(posedge clk) begin
    if (rst) begin
      r0 <= '0; r1 <= '0; r2 <= '0; fc0 <= '0; fc1 <= '0;
      prev_u <= '0; face_two <= '0; cell_count <= '0;
    end else begin
      if (accept) begin
        r0 <= r1; r1 <= r2; r2 <= cells.cell_value;
        if (cell_count == 17'd0) fc0 <= cells.cell_value;
        if (cell_count == 17'd1) fc1 <= cells.cell_value;
      end
      if (state == plfx_pkg::ST_DISPATCH && k < 17'd2)
        cell_count <= fin ? '0 : k + 1'b1;
      if (state == plfx_pkg::ST_WAIT && fu_done && job == plfx_pkg::JOB_LAST) begin
        if (k == 17'd2) face_two <= fu_face;
        if (!fin) cell_count <= k + 1'b1;
        else      cell_count <= '0;
      end
      // previous face moves on once its flux word is out; third cell has no word
      if (state_next == plfx_pkg::ST_IDLE && state != plfx_pkg::ST_IDLE && k >= 17'd2)
        prev_u <= (state == plfx_pkg::ST_WAIT) ? fu_face : u_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      k   <= cell_count;
      fin <= cells.final_cell || (cell_count >= plfx_pkg::LAST_K);
      job <= plfx_pkg::JOB_LAST;
    end
    if (state == plfx_pkg::ST_WAIT && fu_done) begin
      case (job)
        plfx_pkg::JOB_U0: u0 <= fu_face;
        plfx_pkg::JOB_U1: u1 <= fu_face;
        default:          u_last <= fu_face;
      endcase
      job  <= job + 2'd1;
      step <= (k > 17'd2) ? plfx_pkg::STEP_PREV : plfx_pkg::STEP_WRAP;
    end
    if (state == plfx_pkg::ST_EMIT && slot_free) step <= step + 3'd1;
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      fluxes.valid <= 1'b0;
    end else if (state == plfx_pkg::ST_EMIT && slot_free) begin
      fluxes.valid          <= 1'b1;
      fluxes.face_index     <= idx_sel;
      fluxes.face_flux      <= plfx_pkg::flux_of(ua, ub);
      fluxes.grid_done      <= (step == plfx_pkg::STEP_DUP);
      fluxes.grid_too_short <= 1'b0;
    end else if (state == plfx_pkg::ST_ERR && slot_free) begin
      fluxes.valid          <= 1'b1;
      fluxes.face_index     <= '0;
      fluxes.face_flux      <= '0;
      fluxes.grid_done      <= 1'b1;
      fluxes.grid_too_short <= 1'b1;
    end else if (fluxes.ready) begin
      fluxes.valid <= 1'b0;
    end
  end

endmodule

### rtl/plfx_checker.sv
// Port-level checks for periodic_limited_face_flux_top, bound to it below.
// Depends on plfx_pkg.
module plfx_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [plfx_pkg::DATA_W-1:0] face_flux,
  input logic                               grid_done,
  input logic                               grid_too_short
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(face_flux))
    else $error("stalled word dropped or changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("cell taken while busy");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && grid_too_short |-> grid_done && face_flux == '0)
    else $error("bad short-grid word");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("word pending after reset");

endmodule

bind periodic_limited_face_flux_top plfx_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(cells.valid), .in_ready(cells.ready),
  .out_valid(fluxes.valid), .out_ready(fluxes.ready),
  .face_flux(fluxes.face_flux), .grid_done(fluxes.grid_done),
  .grid_too_short(fluxes.grid_too_short)
);
